FILE: sv/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types, token codes and keyword/operator tables for the C subset
// tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

   // scanner states, one-hot
   typedef enum logic [15:0] {
      ST_IDLE     = 16'b0000_0000_0000_0001,
      ST_WORD     = 16'b0000_0000_0000_0010,
      ST_OP       = 16'b0000_0000_0000_0100,
      ST_ZERO     = 16'b0000_0000_0000_1000,
      ST_ZERO_X   = 16'b0000_0000_0001_0000,
      ST_DEC      = 16'b0000_0000_0010_0000,
      ST_HEX      = 16'b0000_0000_0100_0000,
      ST_SUFFIX   = 16'b0000_0000_1000_0000,
      ST_CH_OPEN  = 16'b0000_0001_0000_0000,
      ST_CH_ESC   = 16'b0000_0010_0000_0000,
      ST_CH_HEX0  = 16'b0000_0100_0000_0000,
      ST_CH_HEX   = 16'b0000_1000_0000_0000,
      ST_CH_CLOSE = 16'b0001_0000_0000_0000,
      ST_STR      = 16'b0010_0000_0000_0000,
      ST_STR_ESC  = 16'b0100_0000_0000_0000,
      ST_STR_X    = 16'b1000_0000_0000_0000
   } scan_state_type;

   // token kinds
   localparam logic [6:0] K_OP_BASE = 7'd26;
   localparam logic [6:0] K_IDENT   = 7'd71;
   localparam logic [6:0] K_INT     = 7'd72;
   localparam logic [6:0] K_UINT    = 7'd73;
   localparam logic [6:0] K_CHAR    = 7'd74;
   localparam logic [6:0] K_STRING  = 7'd75;
   localparam logic [6:0] K_END     = 7'd76;
   localparam logic [6:0] K_ERROR   = 7'd77;

   // error codes
   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_BAD_CHAR   = 4'd1;
   localparam logic [3:0] ERR_EARLY_END  = 4'd2;
   localparam logic [3:0] ERR_OVERFLOW   = 4'd3;
   localparam logic [3:0] ERR_SUFFIX     = 4'd4;
   localparam logic [3:0] ERR_INT_MAX    = 4'd5;
   localparam logic [3:0] ERR_NO_HEX     = 4'd6;
   localparam logic [3:0] ERR_ESC_RANGE  = 4'd7;
   localparam logic [3:0] ERR_BAD_ESC    = 4'd8;
   localparam logic [3:0] ERR_EMPTY_CHAR = 4'd9;
   localparam logic [3:0] ERR_NO_CLOSE   = 4'd10;
   localparam logic [3:0] ERR_STR_NL     = 4'd11;
   localparam logic [3:0] ERR_STR_OPEN   = 4'd12;

   // special characters
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_QUOTE  = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_UNDER  = 8'h5f;

   // output buffer depth, room for the largest burst of one item and more
   localparam int RSP_DEPTH = 8;
   localparam int RSP_BURST = 4;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [6:0]  kind;
      logic [23:0] start_pos;
      logic [23:0] length;
      logic [31:0] value;
      logic [3:0]  err_code;
      logic        run_last;
   } result_type;

   // scanner state apart from positions
   typedef struct packed {
      scan_state_type scan;
      logic [31:0]    accum;
      logic [25:0]    kw_mask;
      logic [15:0]    pend;
      logic [1:0]     pend_n;
      logic [1:0]     flags;   // bit0 hex, bit1 u seen
      logic           halted;
   } lex_state_type;

   localparam logic [103:0] KW_TEXT [26] = '{
      "return", "void", "if", "else", "do", "while", "for", "goto", "break",
      "continue", "static", "extern", "switch", "case", "default", "int",
      "unsigned", "signed", "long", "short", "char", "sizeof", "__attribute__",
      "struct", "union", "enum"};
   localparam int KW_LEN [26] = '{6, 4, 2, 4, 2, 5, 3, 4, 5, 8, 6, 6, 6, 4, 7,
      3, 8, 6, 4, 5, 4, 6, 13, 6, 5, 4};

   localparam logic [23:0] OP_TEXT [45] = '{
      ".", "->", ",", "?", ":", ";", "(", ")", "{", "}", "[", "]", "~",
      "++", "--", "+=", "-=", "*=", "/=", "%=", "+", "-", "*", "/", "%",
      "&&", "||", "&=", "|=", "^=", ">>=", "<<=", "&", "|", "^", ">>", "<<",
      "!=", "!", "==", ">=", "<=", "=", ">", "<"};
   localparam int OP_LEN [45] = '{1, 2, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
      2, 2, 2, 2, 2, 2, 2, 1, 1, 1, 1, 1, 2, 2, 2, 2, 2, 3, 3, 1, 1, 1, 2, 2,
      2, 1, 2, 2, 2, 1, 1, 1};

   function automatic logic is_sp(logic [7:0] c);
      return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
   endfunction

   function automatic logic is_dig(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_wordch(logic [7:0] c);
      return is_alpha(c) || is_dig(c) || c == CH_UNDER;
   endfunction

   // {valid, digit value}
   function automatic logic [4:0] hex_val(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (is_dig(c)) r = {1'b1, 4'(c - "0")};
      else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - "a" + 8'd10)};
      else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - "A" + 8'd10)};
      return r;
   endfunction

   // {valid, escaped value}
   function automatic logic [8:0] esc_val(logic [7:0] c);
      logic [8:0] r;
      r = 9'd0;
      case (c)
         CH_QUOTE, CH_DQUOTE, "?", CH_BSLASH: r = {1'b1, c};
         "a": r = {1'b1, 8'd7};
         "b": r = {1'b1, 8'd8};
         "f": r = {1'b1, 8'd12};
         "n": r = {1'b1, 8'd10};
         "r": r = {1'b1, 8'd13};
         "t": r = {1'b1, 8'd9};
         "v": r = {1'b1, 8'd11};
         "0": r = {1'b1, 8'd0};
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // keywords whose character at idx equals c; idx 15 means past every keyword
   function automatic logic [25:0] kw_match(logic [7:0] c, logic [3:0] idx);
      logic [25:0] m;
      m = '0;
      for (int k = 0; k < 26; k++) begin
         if (int'(idx) < KW_LEN[k]) begin
            if (8'(KW_TEXT[k] >> (8 * (KW_LEN[k] - 1 - int'(idx)))) == c) m[k] = 1'b1;
         end
      end
      return m;
   endfunction

   function automatic logic [6:0] kw_pick(logic [25:0] mask, logic [3:0] len);
      logic [6:0] r;
      r = K_IDENT;
      for (int k = 25; k >= 0; k--) begin
         if (mask[k] && KW_LEN[k] == int'(len)) r = 7'(k);
      end
      return r;
   endfunction

   // some operator starts with the first n bytes (longer: and is longer than n)
   function automatic logic op_hit(logic [2:0][7:0] b, logic [1:0] n, logic longer);
      logic any, ok;
      any = 1'b0;
      for (int i = 0; i < 45; i++) begin
         ok = (OP_LEN[i] >= int'(n)) && !(longer && OP_LEN[i] == int'(n));
         for (int j = 0; j < 3; j++) begin
            if (j < int'(n) && j < OP_LEN[i]) begin
               if (8'(OP_TEXT[i] >> (8 * (OP_LEN[i] - 1 - j))) != b[j]) ok = 1'b0;
            end
         end
         if (ok) any = 1'b1;
      end
      return any;
   endfunction

   function automatic logic [6:0] op_kind(logic [2:0][7:0] b, logic [1:0] n);
      logic [6:0] r;
      logic ok;
      r = K_OP_BASE;
      for (int i = 44; i >= 0; i--) begin
         ok = (OP_LEN[i] == int'(n));
         for (int j = 0; j < 3; j++) begin
            if (j < int'(n) && j < OP_LEN[i]) begin
               if (8'(OP_TEXT[i] >> (8 * (OP_LEN[i] - 1 - j))) != b[j]) ok = 1'b0;
            end
         end
         if (ok) r = K_OP_BASE + 7'(i);
      end
      return r;
   endfunction

endpackage

FILE: sv/cst_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_chan_if
// Valid/ready channel carrying one item of a given payload type.
// ----------------------------------------------------------------------------
interface cst_chan_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

FILE: sv/cst_feed.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_feed
// Combinational scanner pass: runs one byte through the token state machine,
// following re-dispatches, and gives up to three tokens.
// ----------------------------------------------------------------------------
module cst_feed #(
   parameter int POS_BITS = 24
) (
   input  cst_pkg::lex_state_type       st_i,
   input  logic [POS_BITS-1:0]          tok_i,
   input  logic [7:0]                   ch_i,
   input  logic [POS_BITS-1:0]          pos_i,
   output cst_pkg::lex_state_type       st_o,
   output logic [POS_BITS-1:0]          tok_o,
   output cst_pkg::result_type [3:0]    res_o,
   output logic [1:0]                   cnt_o
);

   function automatic cst_pkg::result_type mk(logic [6:0] kind, logic [POS_BITS-1:0] start,
                                              logic [23:0] len, logic [31:0] val,
                                              logic [3:0] err);
      cst_pkg::result_type r;
      r.kind      = kind;
      r.start_pos = 24'(start);
      r.length    = len;
      r.value     = val;
      r.err_code  = err;
      r.run_last  = 1'b0;
      return r;
   endfunction

   // walk the state machine; a byte can pass through at most five states
   always_comb begin
      cst_pkg::lex_state_type    s;
      logic [POS_BITS-1:0]       tok;
      logic [POS_BITS-1:0]       spn;
      logic [3:0]                idx;
      logic                      done;
      logic [1:0]                cnt;
      cst_pkg::result_type [3:0] res;
      cst_pkg::result_type       er;
      logic                      raise;
      logic [2:0][7:0]           b;
      logic [1:0]                nn;
      logic [4:0]                hx;
      logic [8:0]                ev;
      logic [35:0]               prod;
      logic [6:0]                kd;

      s    = st_i;
      tok  = tok_i;
      done = st_i.halted;
      cnt  = 2'd0;
      res  = '0;
      for (int it = 0; it < 5; it++) begin
         if (!done) begin
            spn   = pos_i - tok;
            idx   = (spn > POS_BITS'(14)) ? 4'd15 : spn[3:0];
            hx    = cst_pkg::hex_val(ch_i);
            ev    = cst_pkg::esc_val(ch_i);
            raise = 1'b0;
            er    = mk(cst_pkg::K_ERROR, pos_i, 24'd0, 32'd0, cst_pkg::ERR_NONE);
            b     = '0;
            nn    = 2'd0;
            prod  = '0;
            kd    = cst_pkg::K_INT;
            unique case (s.scan)
               cst_pkg::ST_IDLE: begin
                  done = 1'b1;
                  b    = {8'h00, 8'h00, ch_i};
                  if (ch_i == cst_pkg::CH_NUL) begin
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(cst_pkg::K_END, pos_i, 24'd0, 32'd0, cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     s.halted = 1'b1;
                  end else if (!cst_pkg::is_sp(ch_i)) begin
                     tok = pos_i;
                     if (cst_pkg::is_alpha(ch_i) || ch_i == cst_pkg::CH_UNDER) begin
                        s.kw_mask = cst_pkg::kw_match(ch_i, 4'd0);
                        s.scan    = cst_pkg::ST_WORD;
                     end else if (cst_pkg::is_dig(ch_i)) begin
                        s.accum = 32'(ch_i - "0");
                        s.flags = 2'b00;
                        s.scan  = (ch_i == "0") ? cst_pkg::ST_ZERO : cst_pkg::ST_DEC;
                     end else if (ch_i == cst_pkg::CH_QUOTE) begin
                        s.scan = cst_pkg::ST_CH_OPEN;
                     end else if (ch_i == cst_pkg::CH_DQUOTE) begin
                        s.scan = cst_pkg::ST_STR;
                     end else if (cst_pkg::op_hit(b, 2'd1, 1'b0)) begin
                        s.pend   = {8'h00, ch_i};
                        s.pend_n = 2'd1;
                        if (!cst_pkg::op_hit(b, 2'd1, 1'b1)) begin
                           if (cnt != 2'd3) begin
                              res[cnt] = mk(cst_pkg::op_kind(b, 2'd1), pos_i, 24'd1, 32'd0,
                                            cst_pkg::ERR_NONE);
                              cnt = cnt + 2'd1;
                           end
                           s.scan = cst_pkg::ST_IDLE;
                        end else begin
                           s.scan = cst_pkg::ST_OP;
                        end
                     end else begin
                        raise = 1'b1;
                        er.err_code = cst_pkg::ERR_BAD_CHAR;
                     end
                  end
               end
               cst_pkg::ST_WORD: begin
                  if (cst_pkg::is_wordch(ch_i)) begin
                     s.kw_mask = s.kw_mask & cst_pkg::kw_match(ch_i, idx);
                     done = 1'b1;
                  end else begin
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(cst_pkg::kw_pick(s.kw_mask, idx), tok, 24'(spn),
                                      32'd0, cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     s.scan = cst_pkg::ST_IDLE;
                  end
               end
               cst_pkg::ST_OP: begin
                  if (s.pend_n == 2'd2) begin
                     b  = {ch_i, s.pend[15:8], s.pend[7:0]};
                     nn = 2'd3;
                  end else begin
                     b  = {8'h00, ch_i, s.pend[7:0]};
                     nn = 2'd2;
                  end
                  if (cst_pkg::op_hit(b, nn, 1'b0)) begin
                     done = 1'b1;
                     if (!cst_pkg::op_hit(b, nn, 1'b1)) begin
                        if (cnt != 2'd3) begin
                           res[cnt] = mk(cst_pkg::op_kind(b, nn), tok, 24'(nn), 32'd0,
                                         cst_pkg::ERR_NONE);
                           cnt = cnt + 2'd1;
                        end
                        s.scan = cst_pkg::ST_IDLE;
                     end else begin
                        s.pend   = {ch_i, s.pend[7:0]};
                        s.pend_n = nn;
                     end
                  end else begin
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(cst_pkg::op_kind(b, nn - 2'd1), tok, 24'(nn - 2'd1),
                                      32'd0, cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     s.scan = cst_pkg::ST_IDLE;
                  end
               end
               cst_pkg::ST_ZERO: begin
                  if (ch_i == "x" || ch_i == "X") begin
                     s.pend = {8'h00, ch_i};
                     s.scan = cst_pkg::ST_ZERO_X;
                     done   = 1'b1;
                  end else begin
                     s.scan = cst_pkg::ST_DEC;
                  end
               end
               cst_pkg::ST_ZERO_X: begin
                  if (hx[4]) begin
                     s.accum = 32'(hx[3:0]);
                     s.flags = 2'b01;
                     s.scan  = cst_pkg::ST_HEX;
                     done    = 1'b1;
                  end else begin
                     // a lone 0, then the x opens an identifier one byte back
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(cst_pkg::K_INT, tok, 24'd1, 32'd0, cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     tok       = pos_i - POS_BITS'(1);
                     s.kw_mask = cst_pkg::kw_match(s.pend[7:0], 4'd0);
                     s.scan    = cst_pkg::ST_WORD;
                  end
               end
               cst_pkg::ST_DEC: begin
                  if (cst_pkg::is_dig(ch_i)) begin
                     done = 1'b1;
                     prod = {1'b0, s.accum, 3'b000} + {3'b000, s.accum, 1'b0}
                          + 36'(ch_i - "0");
                     if (prod[35:32] != 4'd0) begin
                        raise = 1'b1;
                        er    = mk(cst_pkg::K_ERROR, tok, 24'd0, 32'd0, cst_pkg::ERR_OVERFLOW);
                     end else begin
                        s.accum = prod[31:0];
                     end
                  end else begin
                     s.scan = cst_pkg::ST_SUFFIX;
                  end
               end
               cst_pkg::ST_HEX: begin
                  if (hx[4]) begin
                     done = 1'b1;
                     if (s.accum[31:28] != 4'd0) begin
                        raise = 1'b1;
                        er    = mk(cst_pkg::K_ERROR, tok, 24'd0, 32'd0, cst_pkg::ERR_OVERFLOW);
                     end else begin
                        s.accum = {s.accum[27:0], hx[3:0]};
                     end
                  end else begin
                     s.scan = cst_pkg::ST_SUFFIX;
                  end
               end
               cst_pkg::ST_SUFFIX: begin
                  if ((ch_i == "u" || ch_i == "U") && !s.flags[1]) begin
                     s.flags[1] = 1'b1;
                     done = 1'b1;
                  end else if (ch_i == "l" || ch_i == "L") begin
                     raise = 1'b1;
                     er    = mk(cst_pkg::K_ERROR, tok, 24'd0, 32'd0, cst_pkg::ERR_SUFFIX);
                  end else if (!s.flags[1] && s.accum[31] && !s.flags[0]) begin
                     raise = 1'b1;
                     er    = mk(cst_pkg::K_ERROR, tok, 24'd0, 32'd0, cst_pkg::ERR_INT_MAX);
                  end else begin
                     kd = (s.flags[1] || s.accum[31]) ? cst_pkg::K_UINT : cst_pkg::K_INT;
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(kd, tok, 24'(spn), s.accum, cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     s.scan = cst_pkg::ST_IDLE;
                  end
               end
               cst_pkg::ST_CH_OPEN: begin
                  done = 1'b1;
                  if (ch_i == cst_pkg::CH_NUL) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_EARLY_END;
                  end else if (ch_i == cst_pkg::CH_NL || ch_i == cst_pkg::CH_QUOTE) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_EMPTY_CHAR;
                  end else if (ch_i == cst_pkg::CH_BSLASH) begin
                     s.scan = cst_pkg::ST_CH_ESC;
                  end else begin
                     s.accum = 32'(ch_i);
                     s.scan  = cst_pkg::ST_CH_CLOSE;
                  end
               end
               cst_pkg::ST_CH_ESC: begin
                  done = 1'b1;
                  if (ch_i == "x") begin
                     s.accum = 32'd0;
                     s.scan  = cst_pkg::ST_CH_HEX0;
                  end else if (!ev[8]) begin
                     raise = 1'b1;
                     er    = mk(cst_pkg::K_ERROR, tok + POS_BITS'(1), 24'd0, 32'd0,
                                cst_pkg::ERR_BAD_ESC);
                  end else begin
                     s.accum = 32'(ev[7:0]);
                     s.scan  = cst_pkg::ST_CH_CLOSE;
                  end
               end
               cst_pkg::ST_CH_HEX0: begin
                  done = 1'b1;
                  if (!hx[4]) begin
                     raise = 1'b1;
                     er    = mk(cst_pkg::K_ERROR, tok + POS_BITS'(2), 24'd0, 32'd0,
                                cst_pkg::ERR_NO_HEX);
                  end else begin
                     s.accum = 32'(hx[3:0]);
                     s.scan  = cst_pkg::ST_CH_HEX;
                  end
               end
               cst_pkg::ST_CH_HEX: begin
                  if (hx[4]) begin
                     done = 1'b1;
                     if (s.accum[31:4] != 28'd0) begin
                        raise = 1'b1;
                        er.err_code = cst_pkg::ERR_ESC_RANGE;
                     end else begin
                        s.accum = {s.accum[27:0], hx[3:0]};
                     end
                  end else begin
                     s.scan = cst_pkg::ST_CH_CLOSE;
                  end
               end
               cst_pkg::ST_CH_CLOSE: begin
                  done = 1'b1;
                  if (cst_pkg::is_sp(ch_i)) begin
                     s.scan = cst_pkg::ST_CH_CLOSE;
                  end else if (ch_i == cst_pkg::CH_QUOTE) begin
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(cst_pkg::K_CHAR, tok, 24'(spn) + 24'd1,
                                      {24'd0, s.accum[7:0]}, cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     s.scan = cst_pkg::ST_IDLE;
                  end else begin
                     raise = 1'b1;
                     er.err_code = (ch_i == cst_pkg::CH_NUL) ? cst_pkg::ERR_EARLY_END
                                                            : cst_pkg::ERR_NO_CLOSE;
                  end
               end
               cst_pkg::ST_STR: begin
                  done = 1'b1;
                  if (ch_i == cst_pkg::CH_NUL) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_STR_OPEN;
                  end else if (ch_i == cst_pkg::CH_NL) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_STR_NL;
                  end else if (ch_i == cst_pkg::CH_DQUOTE) begin
                     if (cnt != 2'd3) begin
                        res[cnt] = mk(cst_pkg::K_STRING, tok, 24'(spn) + 24'd1, 32'd0,
                                      cst_pkg::ERR_NONE);
                        cnt = cnt + 2'd1;
                     end
                     s.scan = cst_pkg::ST_IDLE;
                  end else if (ch_i == cst_pkg::CH_BSLASH) begin
                     s.scan = cst_pkg::ST_STR_ESC;
                  end
               end
               cst_pkg::ST_STR_ESC: begin
                  done = 1'b1;
                  if (ch_i == cst_pkg::CH_NUL) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_STR_OPEN;
                  end else if (ch_i == cst_pkg::CH_NL) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_STR_NL;
                  end else if (ch_i == "x") begin
                     s.scan = cst_pkg::ST_STR_X;
                  end else if (!ev[8]) begin
                     raise = 1'b1;
                     er.err_code = cst_pkg::ERR_BAD_ESC;
                  end else begin
                     s.scan = cst_pkg::ST_STR;
                  end
               end
               cst_pkg::ST_STR_X: begin
                  done = 1'b1;
                  if (!hx[4]) begin
                     raise = 1'b1;
                     er    = mk(cst_pkg::K_ERROR, pos_i - POS_BITS'(1), 24'd0, 32'd0,
                                cst_pkg::ERR_NO_HEX);
                  end else begin
                     s.scan = cst_pkg::ST_STR;
                  end
               end
               default: begin
                  s.scan = cst_pkg::ST_IDLE;
               end
            endcase
            // error: report once and halt
            if (raise) begin
               if (cnt != 2'd3) begin
                  res[cnt] = er;
                  cnt = cnt + 2'd1;
               end
               s.halted = 1'b1;
               done = 1'b1;
            end
         end
      end
      st_o  = s;
      tok_o = tok;
      res_o = res;
      cnt_o = cnt;
   end

endmodule

FILE: sv/cst_rsp_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_rsp_fifo
// Result buffer: takes a burst of up to four tokens per cycle and drains
// one token per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module cst_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [2:0]                    push_cnt,
   input  cst_pkg::result_type [3:0]     push_data,
   output logic                          room,
   cst_chan_if.source                    rsp_if
);

   localparam int AW = $clog2(cst_pkg::RSP_DEPTH);

   cst_pkg::result_type mem_ff [cst_pkg::RSP_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          pop;

   assign pop            = rsp_if.valid && rsp_if.ready;
   assign rsp_if.valid   = (count_ff != '0);
   assign rsp_if.payload = mem_ff[rd_ptr_ff];
   assign room           = (count_ff <= (AW+1)'(cst_pkg::RSP_DEPTH - cst_pkg::RSP_BURST));

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff + AW'(push_cnt);
      rd_ptr_in = rd_ptr_ff + AW'(pop);
      count_in  = count_ff + (AW+1)'(push_cnt) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // burst write of the new tokens
   always_ff @(posedge clock) begin
      for (int i = 0; i < cst_pkg::RSP_BURST; i++) begin
         if (3'(i) < push_cnt) mem_ff[wr_ptr_ff + AW'(i)] <= push_data[i];
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (AW+1)'(cst_pkg::RSP_DEPTH))
      else $error("result buffer overfilled");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push_cnt != 3'd0 |=> rsp_if.valid)
      else $error("pushed item not presented");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push_cnt == 3'd0 |=> count_ff == $past(count_ff) - 1'b1)
      else $error("pop did not drain");

endmodule

FILE: sv/c_subset_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c_subset_tokenizer_top
// Streaming tokenizer for a C subset: one source byte in, zero to four tokens
// out, each with kind, start offset, length, literal value and error code.
// ----------------------------------------------------------------------------
// Usage
//   req_if carries one source byte per item (ch, last). A zero byte or a byte
//   with last set closes the stream; after last the next byte is offset 0.
//   rsp_if carries one token per item; run_last marks the final token that
//   a given input byte caused.
//   Every byte is scanned in the cycle it is accepted; its tokens sit in the
//   result buffer from the next cycle on.
//   Throughput is one byte per cycle; the result buffer drains one token per
//   cycle while the receiver is ready, and the input is taken while it has
//   room for a four-token burst. A byte that causes several tokens therefore
//   holds the input only while the receiver works the buffer down.
//   When the receiver stalls, tokens wait in the buffer and req_if.ready
//   drops once fewer than four entries are free.
//   After an error the block drops bytes until one with last set.
//   Reset clears the scanner to idle at offset zero and empties the buffer.
// ----------------------------------------------------------------------------
module c_subset_tokenizer_top #(
   parameter int POS_BITS = 24
) (
   input  logic       clock,
   input  logic       reset,
   cst_chan_if.sink   req_if,
   cst_chan_if.source rsp_if
);

   cst_pkg::lex_state_type    st_ff, st_in, st1, st2;
   logic [POS_BITS-1:0]       tok_ff, tok_in, tok1, tok2;
   logic [POS_BITS-1:0]       pos_ff, pos_in, pos_nx;
   cst_pkg::result_type [3:0] res1, res2, push_data;
   logic [1:0]                cnt1, cnt2;
   logic [2:0]                n1, n2, total;
   logic                      accept, fin, room;

   localparam cst_pkg::lex_state_type ST_RESET = '{
      scan: cst_pkg::ST_IDLE, accum: 32'd0, kw_mask: 26'h3ffffff, pend: 16'd0,
      pend_n: 2'd0, flags: 2'b00, halted: 1'b0};

   assign req_if.ready = room;
   assign accept       = req_if.valid && req_if.ready;
   assign fin          = req_if.payload.last;
   assign pos_nx       = pos_ff + POS_BITS'(1);

   // scan the byte, then the end marker that a last byte implies
   cst_feed #(.POS_BITS(POS_BITS)) u_feed_byte (
      .st_i(st_ff), .tok_i(tok_ff), .ch_i(req_if.payload.ch), .pos_i(pos_ff),
      .st_o(st1), .tok_o(tok1), .res_o(res1), .cnt_o(cnt1));

   cst_feed #(.POS_BITS(POS_BITS)) u_feed_end (
      .st_i(st1), .tok_i(tok1), .ch_i(cst_pkg::CH_NUL), .pos_i(pos_nx),
      .st_o(st2), .tok_o(tok2), .res_o(res2), .cnt_o(cnt2));

   // gather the tokens of this item and mark the last one
   always_comb begin
      logic [2:0] t;
      n1 = st_ff.halted ? 3'd0 : {1'b0, cnt1};
      n2 = (!st_ff.halted && !st1.halted && fin) ? {1'b0, cnt2} : 3'd0;
      t  = n1 + n2;
      total = (t > 3'(cst_pkg::RSP_BURST)) ? 3'(cst_pkg::RSP_BURST) : t;
      for (int i = 0; i < cst_pkg::RSP_BURST; i++) begin
         if (3'(i) < n1) push_data[i] = res1[i];
         else            push_data[i] = res2[2'(3'(i) - n1)];
         push_data[i].run_last = (3'(i) + 3'd1 == total);
      end
   end

   // next scanner state
   always_comb begin
      st_in  = st_ff;
      tok_in = tok_ff;
      pos_in = pos_ff;
      if (fin) begin
         st_in  = ST_RESET;
         tok_in = '0;
         pos_in = '0;
      end else if (!st_ff.halted) begin
         st_in  = st1;
         tok_in = tok1;
         pos_in = st1.halted ? pos_ff : pos_nx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_RESET;
         tok_ff <= '0;
         pos_ff <= '0;
      end else if (accept) begin
         st_ff  <= st_in;
         tok_ff <= tok_in;
         pos_ff <= pos_in;
      end
   end

   cst_rsp_fifo u_rsp_fifo (
      .clock(clock), .reset(reset), .push_cnt(accept ? total : 3'd0),
      .push_data(push_data), .room(room), .rsp_if(rsp_if));

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && fin |=> pos_ff == '0 && !st_ff.halted && st_ff.scan == cst_pkg::ST_IDLE)
      else $error("stream end did not restart scanner");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(pos_ff) && $stable(st_ff))
      else $error("scanner moved without an item");

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      accept && st_ff.halted && !fin |=> st_ff.halted && $stable(pos_ff))
      else $error("halted scanner resumed early");

endmodule
